### sv/qoe_pkg.sv
// ----------------------------------------------------------------------------
// qoe_pkg
// Shared types, codes and the saturating add of the quadratic objective
// evaluator.
// ----------------------------------------------------------------------------
package qoe_pkg;

  localparam int IDX_W = 4;
  localparam int VAL_W = 16;
  localparam int OBJ_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [OBJ_W-1:0] OBJ_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OBJ_W-1:0] OBJ_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ACT_LIN  = 2'd0,
    ACT_QUAD = 2'd1,
    ACT_ELEM = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE   = 2'd1;

  // matrix write request, mirror entry implied
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] data;
  } qwr_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } qrd_t;

  typedef struct packed {
    logic             sat;
    logic [OBJ_W-1:0] sum;
  } sum_t;

  function automatic sum_t sat_add(input logic signed [OBJ_W-1:0] a,
                                   input logic signed [OBJ_W-1:0] b);
    sum_t                    r;
    logic signed [OBJ_W-1:0] s;
    s = a + b;
    if ((a[OBJ_W-1] == b[OBJ_W-1]) && (s[OBJ_W-1] != a[OBJ_W-1])) begin
      r.sat = 1'b1;
      r.sum = a[OBJ_W-1] ? OBJ_MIN : OBJ_MAX;
    end else begin
      r.sat = 1'b0;
      r.sum = s;
    end
    return r;
  endfunction

endpackage

### sv/qoe_qmem.sv
// ----------------------------------------------------------------------------
// qoe_qmem
// Symmetric coefficient matrix store: one entry per unordered index pair,
// registered read, per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module qoe_qmem
  import qoe_pkg::*;
#(
  parameter int NV = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  qwr_t                    wr,
  input  qrd_t                    rd,
  output logic signed [VAL_W-1:0] rd_data
);

  localparam int IW = $clog2(NV);
  localparam int DEPTH = NV * NV;
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] NV_A = AW'(NV);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [VAL_W-1:0] rd_raw;
  logic             rd_vld;
  logic [IW-1:0]    w_lo, w_hi, r_lo, r_hi;
  logic [AW-1:0]    waddr, raddr;

  // smaller index first, so both mirror positions share one entry
  always_comb begin
    w_lo  = (wr.row < wr.col) ? wr.row[IW-1:0] : wr.col[IW-1:0];
    w_hi  = (wr.row < wr.col) ? wr.col[IW-1:0] : wr.row[IW-1:0];
    r_lo  = (rd.row < rd.col) ? rd.row[IW-1:0] : rd.col[IW-1:0];
    r_hi  = (rd.row < rd.col) ? rd.col[IW-1:0] : rd.row[IW-1:0];
    waddr = AW'(w_lo) * NV_A + AW'(w_hi);
    raddr = AW'(r_lo) * NV_A + AW'(r_hi);
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
    rd_raw <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[waddr] <= 1'b1;
      end
      rd_vld <= valid[raddr];
    end
  end

  assign rd_data = rd_vld ? signed'(rd_raw) : '0;

endmodule

### sv/quadratic_objective_evaluator_top.sv
// ----------------------------------------------------------------------------
// quadratic_objective_evaluator_top
// Computes c.x + (x'Qx >>> 1) over the active variables, with optional
// negation for maximization, through one shared multiply-accumulate pipeline.
// Coefficient writes and elements without the last mark are taken while idle.
// A last element starts the evaluation: for each active row a row slot, then a
// column slot per active variable, on the single shared multiplier pipeline;
// then pipeline drain, combine, negate and output load, or with n = 0 only the
// last three. Input is held off meanwhile; n = active count.
// Reset (synchronous) clears the control and result registers, vectors and
// matrix valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module quadratic_objective_evaluator_top
  import qoe_pkg::*;
#(
  parameter int MAX_VARS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [IDX_W-1:0]            row_index,
  input  logic [IDX_W-1:0]            col_index,
  input  logic signed [VAL_W-1:0]     value,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OBJ_W-1:0]     objective,
  output logic                        saturated,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  // indices are four bits wide, so at most sixteen variables can ever be addressed
  localparam int NV = (MAX_VARS < 16) ? MAX_VARS : 16;
  localparam int IW = $clog2(NV);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_DRAIN,
    ST_FIN,
    ST_NEG,
    ST_DONE
  } state_t;

  state_t state;

  logic [CFG_DATA_W-1:0] num_active;
  logic                  maximize;
  logic [CFG_DATA_W-1:0] n_lim;

  logic signed [VAL_W-1:0] lin_c [NV];
  logic signed [VAL_W-1:0] x_s [NV];

  logic [IW-1:0]           i, j;
  logic signed [VAL_W-1:0] xi;

  logic                    s1_v, s1_quad;
  logic signed [31:0]      s1_prod;
  logic                    s2_v, s2_quad;
  logic signed [47:0]      s2_t;

  logic signed [OBJ_W-1:0] lin, quad, total;
  logic                    sat;

  logic                    in_acc, r_ok, c_ok;
  logic                    iss_v, iss_quad;
  logic signed [VAL_W-1:0] x_rd, mul_a, k;
  logic signed [OBJ_W-1:0] a_op, b_op;
  sum_t                    add_res;
  qwr_t                    qwr;
  qrd_t                    qrd;
  logic signed [VAL_W-1:0] q_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    n_lim = (num_active > CFG_DATA_W'(NV)) ? CFG_DATA_W'(NV) : num_active;
    r_ok  = (CFG_DATA_W'(row_index) < n_lim);
    c_ok  = (CFG_DATA_W'(col_index) < n_lim);
  end

  always_comb begin
    qwr.we   = in_acc && (action == ACT_QUAD) && r_ok && c_ok;
    qwr.row  = row_index;
    qwr.col  = col_index;
    qwr.data = value;
    qrd.row  = IDX_W'(i);
    qrd.col  = IDX_W'(j);
  end

  qoe_qmem #(
    .NV(NV)
  ) u_qmem (
    .clk    (clk),
    .rst    (rst),
    .wr     (qwr),
    .rd     (qrd),
    .rd_data(q_data)
  );

  // issue slot: row slot forms c[i]*x[i], column slot forms x[i]*x[j]
  always_comb begin
    iss_quad = (state == ST_COL);
    iss_v    = (state == ST_ROW) || iss_quad;
    x_rd     = iss_quad ? x_s[j] : x_s[i];
    mul_a    = iss_quad ? xi : lin_c[i];
    k        = s1_quad ? q_data : 16'sd256;
  end

  // one saturating adder, shared by accumulation and the final combine
  always_comb begin
    if (state == ST_FIN) begin
      a_op = lin;
      b_op = quad >>> 1;
    end else begin
      a_op = s2_quad ? quad : lin;
      b_op = {{(OBJ_W-48){s2_t[47]}}, s2_t};
    end
    add_res = sat_add(a_op, b_op);
  end

  // multiply pipeline, no reset on payload
  always_ff @(posedge clk) begin
    s1_prod <= mul_a * x_rd;
    s2_t    <= k * s1_prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_active <= '0;
      maximize   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_ACTIVE: num_active <= cfg_data;
        CFG_MAXIMIZE:   maximize   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NV; e++) begin
        lin_c[e] <= '0;
        x_s[e]   <= '0;
      end
    end else if (in_acc && r_ok) begin
      if (action == ACT_LIN) begin
        lin_c[row_index[IW-1:0]] <= value;
      end else if (action == ACT_ELEM) begin
        x_s[row_index[IW-1:0]] <= value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      i         <= '0;
      j         <= '0;
      xi        <= '0;
      s1_v      <= 1'b0;
      s1_quad   <= 1'b0;
      s2_v      <= 1'b0;
      s2_quad   <= 1'b0;
      lin       <= '0;
      quad      <= '0;
      total     <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
      objective <= '0;
      saturated <= 1'b0;
    end else begin
      s1_v    <= iss_v;
      s1_quad <= iss_quad;
      s2_v    <= s1_v;
      s2_quad <= s1_quad;
      if (s2_v) begin
        if (s2_quad) begin
          quad <= add_res.sum;
        end else begin
          lin <= add_res.sum;
        end
        sat <= sat | add_res.sat;
      end
      // the output load below sets valid itself
      if (out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (action == ACT_ELEM) && last) begin
            lin   <= '0;
            quad  <= '0;
            sat   <= 1'b0;
            i     <= '0;
            j     <= '0;
            state <= (n_lim == '0) ? ST_FIN : ST_ROW;
          end
        end
        ST_ROW: begin
          xi    <= x_rd;
          j     <= '0;
          state <= ST_COL;
        end
        ST_COL: begin
          if (CFG_DATA_W'(j) + CFG_DATA_W'(1) == n_lim) begin
            j <= '0;
            if (CFG_DATA_W'(i) + CFG_DATA_W'(1) == n_lim) begin
              state <= ST_DRAIN;
            end else begin
              i     <= i + IW'(1);
              state <= ST_ROW;
            end
          end else begin
            j <= j + IW'(1);
          end
        end
        ST_DRAIN: begin
          if (!s1_v && !s2_v) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          total <= add_res.sum;
          sat   <= sat | add_res.sat;
          state <= ST_NEG;
        end
        ST_NEG: begin
          if (maximize) begin
            if (total == OBJ_MIN) begin
              total <= OBJ_MAX;
              sat   <= 1'b1;
            end else begin
              total <= -total;
            end
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            objective <= total;
            saturated <= sat;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the pipeline is empty whenever a new item can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!s1_v && !s2_v))
    else $error("multiply pipeline busy while accepting items");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COL) |-> ((CFG_DATA_W'(i) < n_lim) && (CFG_DATA_W'(j) < n_lim)))
    else $error("sequencer index beyond active count");

  // q8.8 magnitudes over at most sixteen variables stay far inside 64 bits
  a_no_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !saturated)
    else $error("objective clamped although range cannot be exceeded");

  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (!s1_v && !s2_v && !iss_v))
    else $error("combine step reached with products in flight");

endmodule
